// ===== sv/crv_pkg.sv =====
`timescale 1ns / 1ps

package crv_pkg;

  // Default number of micro-rotations (1 to 16)
  localparam int unsigned CRV_ITERATIONS = 16;

  // Port field widths
  localparam int unsigned X_IN_W    = 17;
  localparam int unsigned ANG_IN_W  = 24;
  localparam int unsigned X_OUT_W   = 19;
  localparam int unsigned ANG_OUT_W = 25;
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 64;

  // Datapath widths, one bit of headroom over the output fields
  localparam int unsigned XW = 20;
  localparam int unsigned ZW = 26;

  localparam logic MODE_ROTATE = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } crv_data_t;

  // atan(2^-i) in degrees, scaled by 32768 and truncated toward zero
  function automatic logic signed [ZW-1:0] atan_step(input logic [3:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      4'd0:    a = 26'sd1474560;
      4'd1:    a = 26'sd870483;
      4'd2:    a = 26'sd459939;
      4'd3:    a = 26'sd233472;
      4'd4:    a = 26'sd117189;
      4'd5:    a = 26'sd58651;
      4'd6:    a = 26'sd29333;
      4'd7:    a = 26'sd14667;
      4'd8:    a = 26'sd7333;
      4'd9:    a = 26'sd3666;
      4'd10:   a = 26'sd1833;
      4'd11:   a = 26'sd916;
      4'd12:   a = 26'sd458;
      4'd13:   a = 26'sd229;
      4'd14:   a = 26'sd114;
      default: a = 26'sd57;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/crv_stage.sv =====
`timescale 1ns / 1ps

module crv_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  crv_pkg::crv_data_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output crv_pkg::crv_data_t data_o
);
  import crv_pkg::*;

  localparam logic [3:0] TableIdx = 4'(IDX);

  logic                 valid_q;
  crv_data_t            data_d, data_q;
  logic signed [XW-1:0] x_cur, y_cur, xs, ys;
  logic signed [ZW-1:0] z_cur, a;
  logic                 plus;

  always_comb begin
    x_cur = data_i.x;
    y_cur = data_i.y;
    z_cur = data_i.z;
    xs    = x_cur >>> IDX;
    ys    = y_cur >>> IDX;
    a     = atan_step(TableIdx);
    // zero steers as non-negative in both modes
    plus  = (data_i.mode == MODE_VECTOR) ? y_cur[XW-1] : !z_cur[ZW-1];
    data_d.mode = data_i.mode;
    if (plus) begin
      data_d.x = x_cur - ys;
      data_d.y = y_cur + xs;
      data_d.z = z_cur - a;
    end else begin
      data_d.x = x_cur + ys;
      data_d.y = y_cur - xs;
      data_d.z = z_cur + a;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== sv/cordic_rotate_vector_q15_unit.sv =====
`timescale 1ns / 1ps

// Circular CORDIC, one micro-rotation per pipeline stage, ITERATIONS stages.
// Input words arrive on the s_axis channel: tuser carries the mode
// (0 = rotation, steered by the angle sign; 1 = vectoring, steered by the
// sign of y, input angle ignored and accumulator started at zero).
// tdata carries x, y (signed Q15) and the angle (degrees * 32768).
// Result words leave on m_axis: x and y with the CORDIC gain (~1.6468)
// and the residual or accumulated angle.
// Each accepted word passes through the ITERATIONS stage registers in turn
// before m_axis_tvalid rises for it.
// One word per cycle is taken when the output side keeps up. Every stage is
// a register with its own valid bit and holds while the next one is full and stalled,
// so a stall on m_axis fills the pipe and then drops s_axis_tready;
// no word is lost or repeated, and empty slots are squeezed out.
// Reset clears all valid bits; the pipe comes up empty and ready.
module cordic_rotate_vector_q15_unit #(
  parameter int unsigned ITERATIONS = crv_pkg::CRV_ITERATIONS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [16:0] x_in, [33:17] y_in, [57:34] angle_in, rest zero
  input  logic [crv_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] mode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [18:0] x_out, [37:19] y_out, [62:38] angle_out, [63] zero
  output logic [crv_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import crv_pkg::*;

  localparam int unsigned YLo  = X_IN_W;
  localparam int unsigned ALo  = 2 * X_IN_W;
  localparam int unsigned OyLo = X_OUT_W;
  localparam int unsigned OaLo = 2 * X_OUT_W;
  localparam int unsigned OPad = M_TDATA_W - 2 * X_OUT_W - ANG_OUT_W;

  crv_data_t stage_data  [ITERATIONS+1];
  logic      stage_valid [ITERATIONS+1];
  logic      stage_ready [ITERATIONS+1];
  crv_data_t in_data;

  logic signed [X_IN_W-1:0]   x_in, y_in;
  logic signed [ANG_IN_W-1:0] angle_in;

  assign x_in     = s_axis_tdata[X_IN_W-1:0];
  assign y_in     = s_axis_tdata[YLo +: X_IN_W];
  assign angle_in = s_axis_tdata[ALo +: ANG_IN_W];

  always_comb begin
    in_data.mode = s_axis_tuser;
    in_data.x    = XW'(x_in);
    in_data.y    = XW'(y_in);
    in_data.z    = (s_axis_tuser == MODE_VECTOR) ? '0 : ZW'(angle_in);
  end

  assign stage_data[0]  = in_data;
  assign stage_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = stage_ready[0];

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
    crv_stage #(
      .IDX(g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(stage_valid[g]),
      .ready_o(stage_ready[g]),
      .data_i (stage_data[g]),
      .valid_o(stage_valid[g+1]),
      .ready_i(stage_ready[g+1]),
      .data_o (stage_data[g+1])
    );
  end

  assign stage_ready[ITERATIONS] = m_axis_tready;
  assign m_axis_tvalid           = stage_valid[ITERATIONS];

  always_comb begin
    m_axis_tdata                      = '0;
    m_axis_tdata[X_OUT_W-1:0]         = stage_data[ITERATIONS].x[X_OUT_W-1:0];
    m_axis_tdata[OyLo +: X_OUT_W]     = stage_data[ITERATIONS].y[X_OUT_W-1:0];
    m_axis_tdata[OaLo +: ANG_OUT_W]   = stage_data[ITERATIONS].z[ANG_OUT_W-1:0];
    m_axis_tdata[M_TDATA_W-1 -: OPad] = '0;
  end

endmodule
